// ===== hw/rtl/bbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcs_pkg
// Shared widths, constants and control types of the bounding box
// coordinate scaler.
// ----------------------------------------------------------------------------
package bbcs_pkg;

	// field widths
	localparam int COORD_W   = 11;
	localparam int LIMIT_W   = 12;
	localparam int INDEX_W   = 6;
	localparam int PROD_W    = COORD_W + LIMIT_W;
	localparam int QUO_W     = 12;
	localparam int DIV_STEPS = QUO_W;

	// default store depth
	localparam int MAX_POINTS_DEF = 64;

	// coordinate saturation and tracker start values
	localparam logic [COORD_W-1:0] COORD_SAT  = COORD_W'(2000);
	localparam logic [COORD_W-1:0] COORD_ZERO = '0;

	// limit register reset value
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_X_LIMIT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_Y_LIMIT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;    // input word taken this cycle
		logic rd;        // read the store at the emit index
		logic mul;       // offset and product stage
		logic div_load;  // load both dividers
		logic div_step;  // one shift-subtract step
		logic capture;   // load the output register
		logic clear;     // end of run: reset set and emit index
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_last;   // emit index points at the final stored vertex
	} status_t;

endpackage

// ===== hw/rtl/bbcs_div.sv =====
// ----------------------------------------------------------------------------
// bbcs_div
// Restoring shift-subtract divider, one quotient bit per step. The caller
// guarantees the quotient fits QUO_W bits, so the top dividend bits start
// as the partial remainder.
// ----------------------------------------------------------------------------
module bbcs_div
	import bbcs_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [PROD_W-1:0]  dividend,
	input  logic [COORD_W-1:0] divisor,
	output logic [QUO_W-1:0]   quotient
);

	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] den_q;
	logic [QUO_W-1:0]   work_q;
	logic [COORD_W:0]   trial;
	logic               fits;
	logic [COORD_W:0]   diff;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, work_q[QUO_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// low dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= dividend[PROD_W-1:QUO_W];
			work_q <= dividend[QUO_W-1:0];
			den_q  <= divisor;
		end else if (step) begin
			rem_q  <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			work_q <= {work_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = work_q;

endmodule

// ===== hw/rtl/bbcs_dp.sv =====
// ----------------------------------------------------------------------------
// bbcs_dp
// Datapath: limit registers, vertex store, min/max trackers, offset and
// product stage, two dividers and the output register.
// ----------------------------------------------------------------------------
module bbcs_dp
	import bbcs_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data,
	input  logic [COORD_W-1:0]   x_in,
	input  logic [COORD_W-1:0]   y_in,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic [INDEX_W-1:0]   point_index,
	output logic [LIMIT_W-1:0]   x_out,
	output logic [LIMIT_W-1:0]   y_out,
	output logic                 last_out
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [LIMIT_W-1:0] x_limit_q;
	logic [LIMIT_W-1:0] y_limit_q;

	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

	logic [2*COORD_W-1:0] store_mem [MAX_POINTS];
	logic [2*COORD_W-1:0] rd_s1;

	logic [COORD_W-1:0] x_sat, y_sat;
	logic               has_room;

	logic [COORD_W-1:0] off_x, off_y;
	logic [COORD_W-1:0] off_x_s2, off_y_s2;
	logic [PROD_W-1:0]  prod_x_s2, prod_y_s2;
	logic               flat_x_s2, flat_y_s2;
	logic [QUO_W-1:0]   quo_x, quo_y;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= LIMIT_RESET;
			y_limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_X_LIMIT: x_limit_q <= cfg_data;
				REG_Y_LIMIT: y_limit_q <= cfg_data;
			endcase
		end
	end

	// input saturation
	always_comb begin
		x_sat    = (x_in > COORD_SAT) ? COORD_SAT : x_in;
		y_sat    = (y_in > COORD_SAT) ? COORD_SAT : y_in;
		has_room = count_q < CNT_W'(MAX_POINTS);
	end

	// fill count, emit index and min/max trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			x_min_q <= COORD_SAT;
			x_max_q <= COORD_ZERO;
			y_min_q <= COORD_SAT;
			y_max_q <= COORD_ZERO;
		end else if (cmd.clear) begin
			count_q <= '0;
			idx_q   <= '0;
			x_min_q <= COORD_SAT;
			x_max_q <= COORD_ZERO;
			y_min_q <= COORD_SAT;
			y_max_q <= COORD_ZERO;
		end else begin
			if (cmd.accept && has_room) begin
				count_q <= count_q + CNT_W'(1);
				if (x_sat > x_max_q) x_max_q <= x_sat;
				if (x_sat < x_min_q) x_min_q <= x_sat;
				if (y_sat > y_max_q) y_max_q <= y_sat;
				if (y_sat < y_min_q) y_min_q <= y_sat;
			end
			if (cmd.capture) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign status.is_last = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	// vertex store write
	always_ff @(posedge clk) begin
		if (cmd.accept && has_room) begin
			store_mem[count_q[IDX_W-1:0]] <= {x_sat, y_sat};
		end
	end

	// vertex store registered read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_s1 <= store_mem[idx_q];
		end
	end

	// offset from the axis minimum
	always_comb begin
		off_x = rd_s1[2*COORD_W-1:COORD_W] - x_min_q;
		off_y = rd_s1[COORD_W-1:0] - y_min_q;
	end

	// offset times limit
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			off_x_s2  <= off_x;
			off_y_s2  <= off_y;
			prod_x_s2 <= PROD_W'(off_x) * PROD_W'(x_limit_q);
			prod_y_s2 <= PROD_W'(off_y) * PROD_W'(y_limit_q);
			flat_x_s2 <= x_max_q <= x_min_q;
			flat_y_s2 <= y_max_q <= y_min_q;
		end
	end

	// divide by the axis extent
	bbcs_div u_div_x (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (prod_x_s2),
		.divisor  (x_max_q - x_min_q),
		.quotient (quo_x)
	);

	bbcs_div u_div_y (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (prod_y_s2),
		.divisor  (y_max_q - y_min_q),
		.quotient (quo_y)
	);

	// output register, zero extent passes the offset through
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			point_index <= INDEX_W'(idx_q);
			x_out       <= flat_x_s2 ? LIMIT_W'(off_x_s2) : quo_x;
			y_out       <= flat_y_s2 ? LIMIT_W'(off_y_s2) : quo_y;
			last_out    <= status.is_last;
		end
	end

endmodule

// ===== hw/rtl/bbcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbcs_ctrl
// Controller: takes input words while loading, then walks the store one
// vertex at a time through read, product, divide and output.
// ----------------------------------------------------------------------------
module bbcs_ctrl
	import bbcs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    last_point,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_PUT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:  cmd.accept   = in_valid;
			ST_READ:  cmd.rd       = 1'b1;
			ST_MUL:   cmd.mul      = 1'b1;
			ST_DLOAD: cmd.div_load = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_PUT: begin
				cmd.capture = slot_free;
				cmd.clear   = slot_free && status.is_last;
			end
		endcase
	end

	// state, divide step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raised on capture, dropped once the word is taken
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid && last_point) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DLOAD;
				ST_DLOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (slot_free) begin
						state_q <= status.is_last ? ST_LOAD : ST_READ;
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/bounding_box_coordinate_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// bounding_box_coordinate_scaler_unit
// Collects a set of vertices, tracks the per-axis bounding box and emits
// every vertex shifted to the box origin and scaled to the axis limit.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall): one vertex per word; words are
//   taken one per cycle while the set is loading. A vertex beyond the store
//   depth is dropped, but its last_point flag still starts the emit run.
//   output channel (out_valid / out_stall): one word per stored vertex, in
//   load order, last_out set on the final one.
//   config port: cfg_write with cfg_index 0 writes x_limit, 1 writes y_limit;
//   write only while the block is idle.
// Timing:
//   each emitted word passes through store read, offset and product,
//   divider load, 12 steps of the shift-subtract dividers (one quotient
//   bit a cycle) and output capture. While the output is not stalled,
//   the 12-step divider sets the emit rate. Input stays stalled for the
//   whole emit run; the last word may wait in the output register while a
//   new set loads.
// Reset: limits return to 1000, the set is empty, minima 2000, maxima 0.
// A stalled output word holds; the next vertex is prepared meanwhile and
// waits until the output register frees.
// ----------------------------------------------------------------------------
module bounding_box_coordinate_scaler_unit
	import bbcs_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COORD_W-1:0]   x_in,
	input  logic [COORD_W-1:0]   y_in,
	input  logic                 last_point,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [INDEX_W-1:0]   point_index,
	output logic [LIMIT_W-1:0]   x_out,
	output logic [LIMIT_W-1:0]   y_out,
	output logic                 last_out
);

	cmd_t    cmd;
	status_t status;

	// sequencing
	bbcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// store, trackers and arithmetic
	bbcs_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.x_in        (x_in),
		.y_in        (y_in),
		.cmd         (cmd),
		.status      (status),
		.point_index (point_index),
		.x_out       (x_out),
		.y_out       (y_out),
		.last_out    (last_out)
	);

	// at most one datapath operation a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.rd, cmd.mul, cmd.div_load, cmd.div_step, cmd.capture}))
		else $error("more than one datapath command at once");

	// a pending output word is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !(out_valid && out_stall))
		else $error("output word overwritten while stalled");

	// the set clears only with the capture of its final vertex
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (cmd.capture && status.is_last))
		else $error("set cleared outside the final capture");

	// dividers step right after loading
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> cmd.div_step)
		else $error("divider loaded without stepping");

endmodule
